>>> hdl/ppdt_pkg.sv
// Package with types, constants and helpers for the periodic point dedup table.
`default_nettype none
package ppdt_pkg;
   localparam int TableDepth = 1024;
   localparam int SlotW = $clog2(TableDepth);
   localparam int CountW = $clog2(TableDepth + 1);

   localparam logic [2:0] VerdictAppend   = 3'd0;
   localparam logic [2:0] VerdictReplaced = 3'd1;
   localparam logic [2:0] VerdictKept     = 3'd2;
   localparam logic [2:0] VerdictSmall    = 3'd3;
   localparam logic [2:0] VerdictFull     = 3'd4;
   localparam logic [2:0] VerdictRead     = 3'd5;

   localparam logic [2:0] RegBoxX  = 3'd0;
   localparam logic [2:0] RegBoxY  = 3'd1;
   localparam logic [2:0] RegBoxZ  = 3'd2;
   localparam logic [2:0] RegLimit = 3'd3;
   localparam logic [2:0] RegDiam  = 3'd4;

   typedef struct packed {
      logic              mode;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]       diam;
      logic [9:0]        read_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]        verdict;
      logic [9:0]        slot;
      logic signed [31:0] entry_x;
      logic signed [31:0] entry_y;
      logic signed [31:0] entry_z;
      logic [31:0]       entry_diam;
      logic [10:0]       entry_count;
   } rsp_type;

   typedef struct packed {
      logic [30:0] box_x;
      logic [30:0] box_y;
      logic [30:0] box_z;
      logic [62:0] limit_sq;
   } geom_type;

   // Saturating square of a 35-bit signed difference.
   function automatic logic [63:0] sat_square(input logic signed [34:0] d);
      logic [34:0] a;
      begin
         a = d[34] ? 35'(-d) : 35'(d);
         if (a[34:32] != 3'd0) sat_square = '1;
         else sat_square = 64'(a[31:0]) * 64'(a[31:0]);
      end
   endfunction

   function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      begin
         s = 65'(a) + 65'(b);
         sat_add = s[64] ? '1 : s[63:0];
      end
   endfunction
endpackage
`default_nettype wire

>>> hdl/ppdt_near.sv
// Pipelined periodic-image distance test of one record against one entry.
`default_nettype none
module ppdt_near (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire ppdt_pkg::geom_type geom,
   input  wire logic signed [31:0] px,
   input  wire logic signed [31:0] py,
   input  wire logic signed [31:0] pz,
   input  wire logic signed [31:0] ex,
   input  wire logic signed [31:0] ey,
   input  wire logic signed [31:0] ez,
   output logic                    out_valid,
   output logic                    out_near
);
   // Stage 1: differences for the three shifts per axis. Stage 2: squares.
   // Stage 3: all 27 sums compared against the limit.
   logic signed [34:0] dx_ff [3], dy_ff [3], dz_ff [3];
   logic [63:0] sx_ff [3], sy_ff [3], sz_ff [3];
   logic [2:0] v_ff;
   logic near_ff;
   logic near_in;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dx_ff[i] <= 35'(px) - 35'(ex) + ((i == 0) ? -35'(geom.box_x) :
                     (i == 2) ? 35'(geom.box_x) : 35'd0);
         dy_ff[i] <= 35'(py) - 35'(ey) + ((i == 0) ? -35'(geom.box_y) :
                     (i == 2) ? 35'(geom.box_y) : 35'd0);
         dz_ff[i] <= 35'(pz) - 35'(ez) + ((i == 0) ? -35'(geom.box_z) :
                     (i == 2) ? 35'(geom.box_z) : 35'd0);
         sx_ff[i] <= ppdt_pkg::sat_square(dx_ff[i]);
         sy_ff[i] <= ppdt_pkg::sat_square(dy_ff[i]);
         sz_ff[i] <= ppdt_pkg::sat_square(dz_ff[i]);
      end
      near_ff <= near_in;
   end

   always_comb begin
      near_in = 1'b0;
      for (int a = 0; a < 3; a++)
         for (int b = 0; b < 3; b++)
            for (int c = 0; c < 3; c++)
               if (ppdt_pkg::sat_add(ppdt_pkg::sat_add(sx_ff[a], sy_ff[b]), sz_ff[c])
                   < {1'b0, geom.limit_sq})
                  near_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   assign out_valid = v_ff[2];
   assign out_near  = near_ff;
endmodule
`default_nettype wire

>>> hdl/periodic_point_dedup_table.sv
// Top level of the periodic point dedup table.
`default_nettype none
// The block keeps up to 1024 unique spheres in a synchronous table memory.
// An offered record (mode 0) is checked against each stored entry in slot
// order. For every entry all 27 periodic images are tested in a four-stage
// pipeline (memory read, difference, square, sum and compare), and one
// entry is examined at a time. A too-small record is answered without a
// scan, and a read (mode 1) fetches the named slot. In every case the input
// then waits while the previous result is still held. The first near entry
// absorbs the record and is overwritten when the record's diameter is larger.
// An unmatched record is appended or, with a full table, dropped. One result
// transaction is given per input transaction. The output register lets the
// block take the next input while a result waits. Configuration must only be
// written while idle.
module periodic_point_dedup_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire ppdt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ppdt_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [63:0]       csr_data
);
   localparam logic [2:0] StIdle  = 3'd0;
   localparam logic [2:0] StRead  = 3'd1;
   localparam logic [2:0] StTest  = 3'd2;
   localparam logic [2:0] StFetch = 3'd3;
   localparam logic [2:0] StDone  = 3'd4;
   localparam logic [2:0] StWait1 = 3'd5;
   localparam logic [2:0] StWait2 = 3'd6;
   localparam logic [2:0] StWait3 = 3'd7;

   // Table memory: one word of x, y, z and diameter per slot.
   logic [127:0] table_mem [ppdt_pkg::TableDepth];
   logic [127:0] rd_data_ff;
   logic [ppdt_pkg::SlotW-1:0] rd_addr;
   logic wr_en;
   logic [ppdt_pkg::SlotW-1:0] wr_addr;
   logic [127:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) table_mem[wr_addr] <= wr_data;
      rd_data_ff <= table_mem[rd_addr];
   end

   logic [2:0] state_ff, state_in;
   ppdt_pkg::req_type req_ff;
   ppdt_pkg::geom_type geom_ff;
   logic [31:0] floor_diam_ff;
   logic [ppdt_pkg::CountW-1:0] count_ff, count_in;
   logic [ppdt_pkg::CountW-1:0] scan_ff, scan_in;
   logic rsp_valid_ff;
   ppdt_pkg::rsp_type rsp_ff, rsp_in;
   logic [2:0] verdict_ff, verdict_in;
   logic show_ff, show_in;
   logic launch;
   logic near_valid, near_hit;
   logic take;

   assign req_ready = (state_ff == StIdle);
   assign take = req_valid && req_ready;
   assign csr_ready = 1'b1;

   ppdt_near u_near (
      .clock(clock), .reset(reset), .in_valid(launch), .geom(geom_ff),
      .px(req_ff.pos_x), .py(req_ff.pos_y), .pz(req_ff.pos_z),
      .ex(rd_data_ff[127:96]), .ey(rd_data_ff[95:64]), .ez(rd_data_ff[63:32]),
      .out_valid(near_valid), .out_near(near_hit)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      verdict_in = verdict_ff;
      show_in    = show_ff;
      launch     = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = scan_ff[ppdt_pkg::SlotW-1:0];
      wr_data    = {req_ff.pos_x, req_ff.pos_y, req_ff.pos_z, req_ff.diam};
      rd_addr    = scan_ff[ppdt_pkg::SlotW-1:0];
      unique case (state_ff)
         StIdle: begin
            if (take) begin
               scan_in = '0;
               if (req_data.mode) begin
                  verdict_in = ppdt_pkg::VerdictRead;
                  scan_in = ppdt_pkg::CountW'(req_data.read_slot);
                  show_in = ppdt_pkg::CountW'(req_data.read_slot) < count_ff;
                  state_in = StFetch;
               end else if (req_data.diam < floor_diam_ff) begin
                  verdict_in = ppdt_pkg::VerdictSmall;
                  show_in = 1'b0;
                  state_in = StDone;
               end else begin
                  state_in = StRead;
               end
            end
         end
         StRead: begin
            // rd_addr = scan; data arrives next cycle.
            if (scan_ff >= count_ff) begin
               if (count_ff < ppdt_pkg::CountW'(ppdt_pkg::TableDepth)) begin
                  wr_en = 1'b1;
                  count_in = count_ff + 1'b1;
                  verdict_in = ppdt_pkg::VerdictAppend;
                  show_in = 1'b1;
                  state_in = StFetch;
               end else begin
                  verdict_in = ppdt_pkg::VerdictFull;
                  show_in = 1'b0;
                  state_in = StDone;
               end
            end else begin
               state_in = StTest;
            end
         end
         StTest: begin
            launch = 1'b1;
            state_in = StWait1;
         end
         StWait1: begin
            // Wait for the compare pipeline.
            state_in = StWait2;
         end
         StWait2: begin
            state_in = StWait3;
         end
         StWait3: begin
            if (near_valid) begin
               if (near_hit) begin
                  show_in = 1'b1;
                  if (req_ff.diam > rd_data_ff[31:0]) begin
                     wr_en = 1'b1;
                     verdict_in = ppdt_pkg::VerdictReplaced;
                  end else begin
                     verdict_in = ppdt_pkg::VerdictKept;
                  end
                  state_in = StFetch;
               end else begin
                  scan_in = scan_ff + 1'b1;
                  state_in = StRead;
               end
            end
         end
         StFetch: begin
            // Read of the reported slot, visible next cycle (after any write).
            state_in = StDone;
         end
         StDone: begin
            if (!rsp_valid_ff || rsp_ready) state_in = StIdle;
         end
         default: state_in = StIdle;
      endcase
   end

   always_comb begin
      rsp_in = rsp_ff;
      rsp_in.verdict = verdict_ff;
      rsp_in.slot = show_ff || verdict_ff == ppdt_pkg::VerdictRead ?
                    scan_ff[ppdt_pkg::SlotW-1:0] : '0;
      rsp_in.entry_x    = show_ff ? rd_data_ff[127:96] : '0;
      rsp_in.entry_y    = show_ff ? rd_data_ff[95:64] : '0;
      rsp_in.entry_z    = show_ff ? rd_data_ff[63:32] : '0;
      rsp_in.entry_diam = show_ff ? rd_data_ff[31:0] : '0;
      rsp_in.entry_count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (take) req_ff <= req_data;
      if (state_ff == StDone && (!rsp_valid_ff || rsp_ready)) rsp_ff <= rsp_in;
      scan_ff    <= scan_in;
      verdict_ff <= verdict_in;
      show_ff    <= show_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         geom_ff       <= {31'd655360, 31'd655360, 31'd655360, 63'd42949673};
         floor_diam_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == StDone && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               ppdt_pkg::RegBoxX:  geom_ff.box_x <= csr_data[30:0];
               ppdt_pkg::RegBoxY:  geom_ff.box_y <= csr_data[30:0];
               ppdt_pkg::RegBoxZ:  geom_ff.box_z <= csr_data[30:0];
               ppdt_pkg::RegLimit: geom_ff.limit_sq <= csr_data[62:0];
               ppdt_pkg::RegDiam:  floor_diam_ff <= csr_data[31:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= ppdt_pkg::CountW'(ppdt_pkg::TableDepth))
      else $error("entry count exceeds table depth");
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == StRead || state_ff == StWait3))
      else $error("table write outside scan");
   assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> $past(verdict_in) == ppdt_pkg::VerdictAppend)
      else $error("count changed without append");
endmodule
`default_nettype wire

>>> tb/periodic_point_dedup_table_test.sv
// Testbench for the periodic point dedup table: directed and random stimulus with a predictor.
`timescale 1ns / 1ps
module periodic_point_dedup_table_test;

   // The watchdog limit covers one offer that scans a full table, the longest
   // result stall, the longest sender gap and the long hold-off, several times.
   localparam int WatchLimit = 60000;
   localparam int HoldCycles = 400;
   localparam int Centers = 48;
   localparam int FillOffers = 110;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ppdt_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ppdt_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = ppdt_pkg::RegBoxX;
   logic [63:0]       csr_data = '0;

   periodic_point_dedup_table dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   // Our own copy of the table and its configuration.
   logic signed [31:0] tab_x [ppdt_pkg::TableDepth];
   logic signed [31:0] tab_y [ppdt_pkg::TableDepth];
   logic signed [31:0] tab_z [ppdt_pkg::TableDepth];
   logic [31:0]        tab_diam [ppdt_pkg::TableDepth];
   int unsigned        tab_count;
   logic [30:0]        box_x, box_y, box_z;
   logic [62:0]        limit_sq;
   logic [31:0]        floor_diam;

   // Results still owed by the block, oldest first.
   ppdt_pkg::rsp_type pending_results [$];

   int errors = 0;
   int items_sent = 0;
   int verdict_seen [6];
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;
   bit run_done = 1'b0;
   int stall_cycles = 0;

   // Cluster centers for the random offers, so that most offers merge and
   // the table stays small enough to keep scans short.
   logic signed [31:0] cen_x [Centers];
   logic signed [31:0] cen_y [Centers];
   logic signed [31:0] cen_z [Centers];

   // ---------------------------------------------------------------------
   // Predictor.
   // ---------------------------------------------------------------------

   // Square of an axis difference, saturating once the magnitude reaches 2^32.
   function automatic logic [63:0] clamp_square(input longint d);
      longint m;
      logic [63:0] a;
      m = (d < 0) ? -d : d;
      if (m >= 64'sh1_0000_0000) return '1;
      a = 64'(m);
      return a * a;
   endfunction

   function automatic logic [63:0] clamp_sum(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // True when one of the 27 periodic images of the record lies near entry k.
   function automatic bit image_near(input int k, input longint px, input longint py,
                                     input longint pz);
      longint ex, ey, ez;
      logic [63:0] sx, sy, sz;
      ex = longint'(tab_x[k]);
      ey = longint'(tab_y[k]);
      ez = longint'(tab_z[k]);
      for (int ix = -1; ix <= 1; ix++) begin
         sx = clamp_square(longint'(ix) * longint'({33'd0, box_x}) + px - ex);
         for (int iy = -1; iy <= 1; iy++) begin
            sy = clamp_square(longint'(iy) * longint'({33'd0, box_y}) + py - ey);
            for (int iz = -1; iz <= 1; iz++) begin
               sz = clamp_square(longint'(iz) * longint'({33'd0, box_z}) + pz - ez);
               if (clamp_sum(clamp_sum(sx, sy), sz) < {1'b0, limit_sq}) return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   // Applies one transaction to the table copy and returns the result it owes.
   function automatic ppdt_pkg::rsp_type dedup_predict(input ppdt_pkg::req_type r);
      ppdt_pkg::rsp_type o;
      bit show, hit;
      int at;
      o = '0;
      show = 1'b0;
      hit = 1'b0;
      at = 0;
      if (r.mode) begin
         o.verdict = ppdt_pkg::VerdictRead;
         at = r.read_slot;
         show = (r.read_slot < tab_count);
      end else if (r.diam < floor_diam) begin
         o.verdict = ppdt_pkg::VerdictSmall;
      end else begin
         o.verdict = ppdt_pkg::VerdictFull;
         for (int k = 0; k < tab_count && !hit; k++) begin
            if (image_near(k, longint'(r.pos_x), longint'(r.pos_y), longint'(r.pos_z))) begin
               hit = 1'b1;
               at = k;
               show = 1'b1;
               if (r.diam > tab_diam[k]) begin
                  tab_x[k] = r.pos_x;
                  tab_y[k] = r.pos_y;
                  tab_z[k] = r.pos_z;
                  tab_diam[k] = r.diam;
                  o.verdict = ppdt_pkg::VerdictReplaced;
               end else begin
                  o.verdict = ppdt_pkg::VerdictKept;
               end
            end
         end
         if (!hit && tab_count < ppdt_pkg::TableDepth) begin
            at = tab_count;
            tab_x[at] = r.pos_x;
            tab_y[at] = r.pos_y;
            tab_z[at] = r.pos_z;
            tab_diam[at] = r.diam;
            tab_count++;
            o.verdict = ppdt_pkg::VerdictAppend;
            show = 1'b1;
         end
      end
      o.slot = at[9:0];
      if (show) begin
         o.entry_x = tab_x[at];
         o.entry_y = tab_y[at];
         o.entry_z = tab_z[at];
         o.entry_diam = tab_diam[at];
      end
      o.entry_count = tab_count[10:0];
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Channels.
   // ---------------------------------------------------------------------

   function automatic int pick_gap();
      if (!idle_on || $urandom_range(0, 3) != 0) return 0;
      return $urandom_range(1, 12);
   endfunction

   // Offers one transaction and predicts its result once it is accepted.
   // Valid is lowered only for a gap, so it is never lowered and raised in
   // the same step.
   task automatic send_item(input ppdt_pkg::req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(dedup_predict(r));
      items_sent++;
   endtask

   // Leaves valid high so that writes follow back to back; the caller lowers
   // it after the last write.
   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      unique case (idx)
         ppdt_pkg::RegBoxX:  box_x = value[30:0];
         ppdt_pkg::RegBoxY:  box_y = value[30:0];
         ppdt_pkg::RegBoxZ:  box_z = value[30:0];
         ppdt_pkg::RegLimit: limit_sq = value[62:0];
         ppdt_pkg::RegDiam:  floor_diam = value[31:0];
         default: ;
      endcase
   endtask

   // Lowers valid and waits until every owed result has come back, plus a
   // few cycles so the block is idle before the next register write.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [30:0] bx, input logic [30:0] by,
                               input logic [30:0] bz, input logic [62:0] lim,
                               input logic [31:0] dmin);
      drain();
      write_reg(ppdt_pkg::RegBoxX, {33'd0, bx});
      write_reg(ppdt_pkg::RegBoxY, {33'd0, by});
      write_reg(ppdt_pkg::RegBoxZ, {33'd0, bz});
      write_reg(ppdt_pkg::RegLimit, {1'b0, lim});
      write_reg(ppdt_pkg::RegDiam, {32'd0, dmin});
      csr_valid <= 1'b0;
   endtask

   function automatic ppdt_pkg::req_type offer(input logic signed [31:0] x,
                                               input logic signed [31:0] y,
                                               input logic signed [31:0] z,
                                               input logic [31:0] d);
      ppdt_pkg::req_type r;
      r = '0;
      r.mode = 1'b0;
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      r.diam = d;
      r.read_slot = 10'($urandom);
      return r;
   endfunction

   // A read below the entry count targets a written slot; one at or beyond
   // it returns no entry data.
   function automatic ppdt_pkg::req_type read_of(input int s);
      ppdt_pkg::req_type r;
      r = '0;
      r.mode = 1'b1;
      r.pos_x = $urandom;
      r.pos_y = $urandom;
      r.pos_z = $urandom;
      r.diam = $urandom;
      r.read_slot = 10'(s);
      return r;
   endfunction

   function automatic logic signed [31:0] jitter();
      return $signed($urandom_range(0, 4000)) - 2000;
   endfunction

   // Mostly offers near a cluster center, some shifted by one box length so
   // that the wrapped images match, some reads, and some raw noise.
   function automatic ppdt_pkg::req_type random_item();
      int c, sel;
      logic signed [31:0] x, y, z;
      c = $urandom_range(0, Centers - 1);
      sel = $urandom_range(0, 99);
      x = cen_x[c] + jitter();
      y = cen_y[c] + jitter();
      z = cen_z[c] + jitter();
      if (sel < 15) begin
         x = x + ($urandom_range(0, 1) ? $signed({1'b0, box_x}) : -$signed({1'b0, box_x}));
         z = z - $signed({1'b0, box_z});
      end
      if (sel >= 80 && sel < 90 && tab_count > 0)
         return read_of($urandom_range(0, tab_count - 1));
      if (sel >= 90) return offer($urandom, $urandom, $urandom, $urandom);
      return offer(x, y, z, $urandom_range(0, 32'h0008_0000));
   endfunction

   // ---------------------------------------------------------------------
   // Result side: stalls, the long hold-off, and the checker.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_request) begin
         rsp_ready <= 1'b0;
         repeat (HoldCycles) @(posedge clock);
         hold_request = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch on %s after %0d transactions: got %h, expected %h",
               what, items_sent, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      ppdt_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("unexpected result transaction: verdict %0d slot %0d",
                     rsp_data.verdict, rsp_data.slot);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.verdict != want.verdict) report("verdict", rsp_data.verdict, want.verdict);
            if (rsp_data.slot != want.slot) report("slot", rsp_data.slot, want.slot);
            if (rsp_data.entry_x != want.entry_x) report("entry_x", rsp_data.entry_x, want.entry_x);
            if (rsp_data.entry_y != want.entry_y) report("entry_y", rsp_data.entry_y, want.entry_y);
            if (rsp_data.entry_z != want.entry_z) report("entry_z", rsp_data.entry_z, want.entry_z);
            if (rsp_data.entry_diam != want.entry_diam)
               report("entry_diam", rsp_data.entry_diam, want.entry_diam);
            if (rsp_data.entry_count != want.entry_count)
               report("entry_count", rsp_data.entry_count, want.entry_count);
            if (want.verdict <= ppdt_pkg::VerdictRead) verdict_seen[want.verdict]++;
         end
      end
   end

   // Watchdog: counts cycles in which no transaction moves on any channel.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchLimit && !run_done) begin
         $display("watchdog expired with %0d results outstanding", pending_results.size());
         $display("** periodic_point_dedup_table: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------

   // Append, replace and keep, a match through a wrapped image, the field
   // extremes, the diameter floor and reads of written slots.
   task automatic test_directed();
      send_item(offer(0, 0, 0, 32'h0001_0000));
      send_item(offer(100, -100, 50, 32'h0002_0000));
      send_item(offer(-50, 0, 0, 32'h0001_8000));
      send_item(offer(655360 - 80, 20, -655360 + 30, 32'h0003_0000));
      send_item(offer(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'h0));
      send_item(offer(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'hFFFF_FFFF));
      send_item(offer(32'sh7FFF_FFF0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'hFFFF_FFFF));
      send_item(offer(32'sh8000_0000, 32'sh8000_0010, 32'sh8000_0000, 32'h1));
      send_item(offer(32'sh4000_0000, -32'sh4000_0000, 32'sh0, 32'h5));
      for (int s = 0; s < 4; s++) send_item(read_of(s));
      set_geometry(31'd655360, 31'd655360, 31'd655360, 63'd42949673, 32'h0002_0000);
      send_item(offer(1 << 20, 1 << 20, 1 << 20, 32'h0001_FFFF));
      send_item(offer(1 << 20, 1 << 20, 1 << 20, 32'h0002_0000));
      send_item(offer(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'h0));
      set_geometry(31'd1, 31'd1, 31'd1, 63'd42949673, 32'hFFFF_FFFF);
      send_item(offer(0, 0, 1, 32'hFFFF_FFFE));
      send_item(offer(1, 0, 0, 32'hFFFF_FFFF));
      send_item(read_of(0));
   endtask

   // Random offers and reads under one geometry setting.
   task automatic test_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
         send_item(random_item());
      end
      idle_on = 1'b1;
   endtask

   // The receiver holds off while offers keep coming, so the block backs up.
   task automatic test_backpressure();
      hold_request = 1'b1;
      for (int i = 0; i < 12; i++) send_item(offer(cen_x[0], cen_y[0], cen_z[0], $urandom));
   endtask

   // With a threshold of zero nothing is ever near, so every offer appends
   // and the scans grow long.
   task automatic test_fill();
      set_geometry(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 63'd0, 32'd0);
      for (int i = 0; i < FillOffers && tab_count < ppdt_pkg::TableDepth; i++)
         send_item(offer($urandom, $urandom, $urandom, $urandom));
      send_item(offer(0, 0, 0, 32'hFFFF_FFFF));
      send_item(offer($urandom, $urandom, $urandom, $urandom));
   endtask

   // Last part, without idling: a well-filled table under the widest
   // threshold, merges and reads of arbitrary slots.
   task automatic test_full_table();
      set_geometry(31'd655360, 31'd655360, 31'd655360, 63'h7FFF_FFFF_FFFF_FFFF, 32'd0);
      idle_on = 1'b0;
      for (int i = 0; i < 30; i++) begin
         if (i % 2 == 0) send_item(read_of($urandom_range(0, ppdt_pkg::TableDepth - 1)));
         else send_item(offer($urandom, $urandom, $urandom, $urandom));
      end
   endtask

   initial begin
      for (int c = 0; c < Centers; c++) begin
         cen_x[c] = $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
         cen_y[c] = $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
         cen_z[c] = $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
      end
      tab_count = 0;
      box_x = 31'd655360;
      box_y = 31'd655360;
      box_z = 31'd655360;
      limit_sq = 63'd42949673;
      floor_diam = 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      set_geometry(31'd655360, 31'd655360, 31'd655360, 63'd42949673, 32'd0);
      test_random(120);
      test_backpressure();
      set_geometry(31'd1, 31'd1, 31'd1, 63'd400000000, 32'h0001_0000);
      test_random(100);
      set_geometry(31'h7FFF_FFFF, 31'd655360, 31'd327680, 63'h7FFF_FFFF_FFFF_FFFF, 32'd0);
      test_random(80);
      set_geometry(31'd655360, 31'd1048576, 31'd655360, 63'd10000000, 32'h0000_4000);
      test_random(100);
      test_fill();
      test_full_table();

      drain();
      run_done = 1'b1;
      $display("%0d transactions offered, table filled to %0d entries", items_sent, tab_count);
      $display("appended %0d, replaced %0d, kept %0d, too small %0d, dropped %0d, read %0d",
               verdict_seen[0], verdict_seen[1], verdict_seen[2], verdict_seen[3],
               verdict_seen[4], verdict_seen[5]);
      if (errors == 0) begin
         $display("** periodic_point_dedup_table: PASSED **");
      end else begin
         $display("** periodic_point_dedup_table: FAILED **");
      end
      $finish;
   end
endmodule

>>> filelist.f
hdl/ppdt_pkg.sv
hdl/ppdt_near.sv
hdl/periodic_point_dedup_table.sv
tb/periodic_point_dedup_table_test.sv
